### sv/uled_pkg.sv
// Shared types, constants and command tables for the UART LED command decoder.
package uled_pkg;

  // Default configuration of the top level
  localparam int unsigned LINE_DEPTH_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Only the first MATCH_WIN characters of a line can ever match a command word
  localparam int unsigned MATCH_WIN    = 8;
  localparam int unsigned MATCH_WIN_AW = 3;
  localparam int unsigned NUM_CMDS     = 7;

  // Configuration port
  localparam int unsigned   APB_AW            = 3;
  localparam logic [0:0]    REG_FLASH_PERIOD  = 1'b0;
  localparam logic [15:0]   FLASH_PERIOD_RST  = 16'd900;

  // Special received bytes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_ENTER = 8'h0D;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_RON      = 4'd1,
    CMD_ROFF     = 4'd2,
    CMD_GON      = 4'd3,
    CMD_GOFF     = 4'd4,
    CMD_RFLASH   = 4'd5,
    CMD_GFLASH   = 4'd6,
    CMD_FLASHOFF = 4'd7,
    CMD_INVALID  = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_RED   = 2'd1,
    MODE_GREEN = 2'd2
  } mode_e;

  // Class of a request as sorted by the front end
  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_IGNORE = 3'd1,
    KIND_ENTER  = 3'd2,
    KIND_ERASE  = 3'd3,
    KIND_CHAR   = 3'd4
  } kind_e;

  // Command words, first character in the low byte, zero padded
  localparam logic [63:0] CMD_WORD [NUM_CMDS] = '{
    {40'h0, "NOR"},
    {32'h0, "FFOR"},
    {40'h0, "NOG"},
    {32'h0, "FFOG"},
    {16'h0, "HSALFR"},
    {16'h0, "HSALFG"},
    "FFOHSALF"
  };
  localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{
    4'd3, 4'd4, 4'd3, 4'd4, 4'd6, 4'd6, 4'd8
  };

  typedef struct packed {
    logic       op;
    logic [7:0] rx_char;
  } in_item_t;

  typedef struct packed {
    cmd_e       command;
    logic       red_led;
    logic       green_led;
    logic [1:0] flash_mode;
    logic [4:0] line_length;
  } out_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### sv/uled_front.sv
// Front end: takes input requests and sorts them into request classes.
module uled_front import uled_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_req_i,
  input  q_stat_t  q_stat_i,
  output logic     push_o,
  output q_item_t  push_item_o
);

  // Take a request whenever the queue has room
  assign in_ready_o = ~q_stat_i.full;
  assign push_o     = in_valid_i & ~q_stat_i.full;

  // Sort the request
  always_comb begin
    push_item_o.ch = in_req_i.rx_char;
    if (in_req_i.op) begin
      push_item_o.kind = KIND_TICK;
    end else if (in_req_i.rx_char == CH_NUL) begin
      push_item_o.kind = KIND_IGNORE;
    end else if (in_req_i.rx_char == CH_ENTER) begin
      push_item_o.kind = KIND_ENTER;
    end else if (in_req_i.rx_char inside {CH_BS, CH_DEL}) begin
      push_item_o.kind = KIND_ERASE;
    end else begin
      push_item_o.kind = KIND_CHAR;
    end
  end

endmodule

### sv/uled_fifo.sv
// Short request queue between the front end and the back end.
module uled_fifo import uled_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t push_item_i,
  input  logic    pop_i,
  output q_item_t pop_item_o,
  output q_stat_t stat_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_item_t         slot_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign pop_item_o   = slot_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold queued requests
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### sv/uled_back.sv
// Back end: line buffer, command match, LED and flash state, result register.
module uled_back import uled_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] flash_period_i,
  input  q_item_t     req_i,
  input  logic        req_valid_i,
  output logic        req_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_rsp_o
);

  localparam int unsigned FW = $clog2(LINE_DEPTH + 1);

  // Only the match window of the line is stored: later characters are never compared
  logic [7:0]    win_q [MATCH_WIN];
  logic [FW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  mode_e         mode_q, mode_d;
  logic [15:0]   tick_q, tick_d;
  logic          red_q, red_d;
  logic          green_q, green_d;
  logic          out_valid_q;
  out_item_t     out_rsp_q;
  cmd_e          match_cmd;
  cmd_e          cmd_d;
  logic          win_we;

  assign req_pop_o   = req_valid_i & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Compare the held line against every command word in parallel
  always_comb begin
    logic eq;
    match_cmd = CMD_INVALID;
    for (int k = NUM_CMDS - 1; k >= 0; k--) begin
      eq = (fill_q == FW'(CMD_LEN[k]));
      for (int i = 0; i < MATCH_WIN; i++) begin
        if ((4'(i) < CMD_LEN[k]) && (win_q[i] != CMD_WORD[k][8*i +: 8])) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        match_cmd = cmd_e'(4'(k + 1));
      end
    end
    if (ovf_q) begin
      match_cmd = CMD_INVALID;
    end
  end

  // Work out the next state for the request at the head of the queue
  always_comb begin
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    mode_d  = mode_q;
    tick_d  = tick_q;
    red_d   = red_q;
    green_d = green_q;
    cmd_d   = CMD_NONE;
    win_we  = 1'b0;
    case (req_i.kind)
      KIND_TICK: begin
        if (tick_q >= flash_period_i) begin
          tick_d = '0;
          case (mode_q)
            MODE_RED:   red_d   = ~red_q;
            MODE_GREEN: green_d = ~green_q;
            default:    ;
          endcase
        end else begin
          tick_d = tick_q + 16'd1;
        end
      end
      KIND_ENTER: begin
        cmd_d  = match_cmd;
        fill_d = '0;
        ovf_d  = 1'b0;
        mode_d = MODE_NONE;
        case (match_cmd)
          CMD_RON:      red_d   = 1'b1;
          CMD_ROFF:     red_d   = 1'b0;
          CMD_GON:      green_d = 1'b1;
          CMD_GOFF:     green_d = 1'b0;
          CMD_RFLASH:   mode_d  = MODE_RED;
          CMD_GFLASH:   mode_d  = MODE_GREEN;
          CMD_FLASHOFF: begin
            red_d   = 1'b0;
            green_d = 1'b0;
          end
          default: ;
        endcase
      end
      KIND_ERASE: begin
        if (fill_q != '0) begin
          fill_d = fill_q - FW'(1);
        end
      end
      KIND_CHAR: begin
        if (fill_q < FW'(LINE_DEPTH)) begin
          fill_d = fill_q + FW'(1);
          win_we = (fill_q < FW'(MATCH_WIN));
        end else begin
          ovf_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Commit state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      mode_q      <= MODE_NONE;
      tick_q      <= '0;
      red_q       <= 1'b0;
      green_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_pop_o) begin
        fill_q  <= fill_d;
        ovf_q   <= ovf_d;
        mode_q  <= mode_d;
        tick_q  <= tick_d;
        red_q   <= red_d;
        green_q <= green_d;
      end
      if (req_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result and store line characters
  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      out_rsp_q.command     <= cmd_d;
      out_rsp_q.red_led     <= red_d;
      out_rsp_q.green_led   <= green_d;
      out_rsp_q.flash_mode  <= mode_d;
      out_rsp_q.line_length <= 5'(fill_d);
      if (win_we) begin
        win_q[fill_q[MATCH_WIN_AW-1:0]] <= req_i.ch;
      end
    end
  end

endmodule

### sv/uart_led_command_decoder_unit.sv
// Top level of the UART LED command decoder: front end, request queue, back end, APB register.
// A request passes through the request queue before the back end registers its result.
// Throughput: one request per cycle while out_ready_i is high and the queue has room.
// The request queue lets input acceptance continue while a result waits on out_ready_i.
// Reset: line length, overflow flag, flash mode, tick counter and both LEDs cleared,
// flash_period set to 900; line characters are undefined until written, no clearing pass.
module uart_led_command_decoder_unit import uled_pkg::*; #(
  parameter int unsigned LINE_DEPTH  = LINE_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic        push;
  q_item_t     push_item;
  q_item_t     head_item;
  q_stat_t     q_stat;
  logic        pop;
  logic [15:0] flash_period_q;
  logic        reg_sel;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1:2] == REG_FLASH_PERIOD);
  assign prdata  = reg_sel ? {16'h0, flash_period_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_period_q <= FLASH_PERIOD_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      flash_period_q <= pwdata[15:0];
    end
  end

  uled_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  uled_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (head_item),
    .stat_o      (q_stat)
  );

  uled_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .flash_period_i (flash_period_q),
    .req_i          (head_item),
    .req_valid_i    (~q_stat.empty),
    .req_pop_o      (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_rsp_o      (out_rsp_o)
  );

`ifndef SYNTHESIS
  // A finished command always leaves an empty line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.command != CMD_NONE) |-> (out_rsp_o.line_length == 5'd0))
    else $error("line not cleared after enter");

  // RFLASH sets the red flash mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.command == CMD_RFLASH) |-> (out_rsp_o.flash_mode == MODE_RED))
    else $error("red flash mode not set");

  // FLASHOFF turns both LEDs off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.command == CMD_FLASHOFF)
      |-> (!out_rsp_o.red_led && !out_rsp_o.green_led && out_rsp_o.flash_mode == MODE_NONE))
    else $error("FLASHOFF left an LED or flash mode on");

  // Queue can never be full and empty at once, and never accepts when full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty) && !(q_stat.full && in_ready_o))
    else $error("request queue status inconsistent");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the UART LED command decoder: directed lines, random lines, ticks.
module tb_top;
  import uled_pkg::*;

  localparam int unsigned LINE_CAP  = LINE_DEPTH_DEF;
  localparam int unsigned NUM_WORDS = 7;
  localparam int unsigned LIMIT     = 1000000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  in_item_t          in_req_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_rsp_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  uart_led_command_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // Command words and the command each one reports
  string cmd_words [NUM_WORDS] = '{"RON", "ROFF", "GON", "GOFF", "RFLASH", "GFLASH", "FLASHOFF"};
  cmd_e  word_cmd  [NUM_WORDS] = '{CMD_RON, CMD_ROFF, CMD_GON, CMD_GOFF,
                                   CMD_RFLASH, CMD_GFLASH, CMD_FLASHOFF};

  // Decoder state as predicted
  logic [7:0]  line_q [LINE_CAP];
  int unsigned fill_q    = 0;
  bit          ovf_q     = 1'b0;
  mode_e       mode_q    = MODE_NONE;
  logic [15:0] tick_q    = '0;
  logic [15:0] period_q  = FLASH_PERIOD_RST;
  logic        red_q     = 1'b0;
  logic        green_q   = 1'b0;

  out_item_t   pending_status_q [$];
  int unsigned req_cnt        = 0;
  int unsigned err_cnt        = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  // Advance the predicted state by one request and return the status it reports
  function automatic out_item_t decode_step(input in_item_t req);
    out_item_t rsp;
    cmd_e      cmd;
    string     w;
    bit        hit;
    cmd = CMD_NONE;
    if (req.op) begin
      if (tick_q >= period_q) begin
        tick_q = '0;
        case (mode_q)
          MODE_RED:   red_q = ~red_q;
          MODE_GREEN: green_q = ~green_q;
          default: ;
        endcase
      end else begin
        tick_q = tick_q + 16'd1;
      end
    end else begin
      case (req.rx_char)
        CH_NUL: ;
        CH_ENTER: begin
          cmd = CMD_INVALID;
          if (!ovf_q) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
              w = cmd_words[k];
              if (w.len() == fill_q) begin
                hit = 1'b1;
                for (int i = 0; i < w.len(); i++) begin
                  if (line_q[i] != w[i]) hit = 1'b0;
                end
                if (hit && cmd == CMD_INVALID) cmd = word_cmd[k];
              end
            end
          end
          case (cmd)
            CMD_RON:      red_q = 1'b1;
            CMD_ROFF:     red_q = 1'b0;
            CMD_GON:      green_q = 1'b1;
            CMD_GOFF:     green_q = 1'b0;
            CMD_FLASHOFF: begin
              red_q   = 1'b0;
              green_q = 1'b0;
            end
            default: ;
          endcase
          mode_q = (cmd == CMD_RFLASH) ? MODE_RED :
                   (cmd == CMD_GFLASH) ? MODE_GREEN : MODE_NONE;
          fill_q = 0;
          ovf_q  = 1'b0;
        end
        CH_BS, CH_DEL: begin
          if (fill_q > 0) fill_q--;
        end
        default: begin
          if (fill_q < LINE_CAP) begin
            line_q[fill_q] = req.rx_char;
            fill_q++;
          end else begin
            ovf_q = 1'b1;
          end
        end
      endcase
    end
    rsp.command     = cmd;
    rsp.red_led     = red_q;
    rsp.green_led   = green_q;
    rsp.flash_mode  = mode_q;
    rsp.line_length = fill_q[4:0];
    return rsp;
  endfunction

  // Random line character: anything but the zero byte, enter and the erase codes
  function automatic logic [7:0] line_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_BS || c == CH_ENTER || c == CH_DEL);
    return c;
  endfunction

  // Offer one request, hold it until accepted, then queue its predicted status
  task automatic send_req(input logic op, input logic [7:0] ch);
    in_item_t req;
    req.op      = op;
    req.rx_char = ch;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_status_q.push_back(decode_step(req));
    req_cnt++;
  endtask

  task automatic send_tick();
    send_req(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_req(1'b0, s[i]);
    send_req(1'b0, CH_ENTER);
  endtask

  // Drop valid, wait for every status to come back, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup phase, then access phase until pready
  task automatic write_period(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FLASH_PERIOD, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    period_q = value;
  endtask

  // Line character with occasional ticks, zero bytes and corrected typos around it
  task automatic send_noisy_char(input logic [7:0] c);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      send_tick();
    end else if (roll < 18) begin
      send_req(1'b0, CH_NUL);
    end else if (roll < 22) begin
      send_req(1'b0, line_char());
      send_req(1'b0, $urandom_range(1) ? CH_BS : CH_DEL);
    end
    send_req(1'b0, c);
  endtask

  // Mostly command words, some mutated, random, empty or padded, at times past the line depth
  task automatic send_random_line();
    string       w;
    logic [7:0]  txt [$];
    int unsigned pick;
    int unsigned total;
    pick = $urandom_range(99);
    w = cmd_words[$urandom_range(NUM_WORDS - 1)];
    for (int i = 0; i < w.len(); i++) txt.push_back(w[i]);
    if (pick >= 55 && pick < 62) begin
      txt.delete();
    end else if (pick >= 62 && pick < 72) begin
      txt[$urandom_range(txt.size() - 1)] = line_char();
    end else if (pick >= 72 && pick < 80) begin
      txt.delete();
      repeat ($urandom_range(1, 10)) txt.push_back(line_char());
    end
    total = txt.size();
    // Pad then erase back to the word; past the depth the line overflows
    if (pick >= 80) total = $urandom_range(txt.size() + 1, LINE_CAP + 4);
    for (int i = 0; i < total; i++) send_noisy_char((i < txt.size()) ? txt[i] : line_char());
    repeat (total - txt.size()) send_req(1'b0, $urandom_range(1) ? CH_BS : CH_DEL);
    send_req(1'b0, CH_ENTER);
  endtask

  // Erase on empty, zero byte, empty line, delete in a word, ticks, field extremes
  task automatic test_directed();
    send_req(1'b0, CH_BS);
    send_req(1'b0, CH_NUL);
    send_req(1'b0, CH_ENTER);
    send_req(1'b0, "R");
    send_req(1'b0, 8'hFF);
    send_req(1'b0, CH_DEL);
    send_line("ON");
    send_req(1'b1, 8'hFF);
    send_req(1'b1, 8'h00);
    send_line("FLASHOFF");
    send_line("X");
  endtask

  // Red flashing at the reset period: needs more than 900 ticks to toggle
  task automatic test_default_period();
    send_line("RFLASH");
    repeat (905) send_tick();
  endtask

  // Random lines, noise and tick bursts at a given flash period
  task automatic test_random(input int unsigned n_req, input logic [15:0] period);
    int unsigned target;
    int unsigned roll;
    wait_idle();
    write_period(period);
    target = req_cnt + n_req;
    while (req_cnt < target) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        send_random_line();
      end else if (roll < 90) begin
        send_req(1'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 2 * period + 2)) send_tick();
      end
    end
  endtask

  // Largest period: a short tick burst must leave green flashing untoggled
  task automatic test_long_period();
    wait_idle();
    write_period(16'hFFFF);
    send_line("GFLASH");
    repeat (40) send_tick();
    send_line("FLASHOFF");
  endtask

  // Compare each returned status with the oldest prediction; drive the stall pattern
  always @(posedge clk_i) begin : chk_status
    out_item_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status_q.size() == 0) begin
        $error("status returned with none pending");
        err_cnt++;
      end else begin
        exp_rsp = pending_status_q.pop_front();
        if (out_rsp_o.command !== exp_rsp.command) begin
          $error("command: expected %0d, actual %0d", exp_rsp.command, out_rsp_o.command);
          err_cnt++;
        end
        if (out_rsp_o.red_led !== exp_rsp.red_led) begin
          $error("red_led: expected %0d, actual %0d", exp_rsp.red_led, out_rsp_o.red_led);
          err_cnt++;
        end
        if (out_rsp_o.green_led !== exp_rsp.green_led) begin
          $error("green_led: expected %0d, actual %0d", exp_rsp.green_led,
                 out_rsp_o.green_led);
          err_cnt++;
        end
        if (out_rsp_o.flash_mode !== exp_rsp.flash_mode) begin
          $error("flash_mode: expected %0d, actual %0d", exp_rsp.flash_mode,
                 out_rsp_o.flash_mode);
          err_cnt++;
        end
        if (out_rsp_o.line_length !== exp_rsp.line_length) begin
          $error("line_length: expected %0d, actual %0d", exp_rsp.line_length,
                 out_rsp_o.line_length);
          err_cnt++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = 8;
    recv_stall_pct = 77;
    test_directed();
    test_default_period();
    test_random(350, 16'd1);

    send_gap_pct   = 77;
    recv_stall_pct = 8;
    test_random(350, 16'($urandom_range(2, 12)));

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random(300, 16'($urandom_range(3, 40)));
    test_long_period();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
